// ===== hw/rtl/trq_pkg.sv =====
// ----------------------------------------------------------------------------
// Thread ready queue package
// Shared constants, operation and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package trq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DEFAULT_ID_BITS     = 8;

    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD       = 2'd0,
        KIND_YIELD     = 2'd1,
        KIND_TERMINATE = 2'd2,
        KIND_QUANTUM   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_APPEND,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/trq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module trq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/trq_ctrl.sv =====
// ----------------------------------------------------------------------------
// Thread ready queue sequencer
// Walks the slot memory one entry a cycle to pop, search and close gaps.
// ----------------------------------------------------------------------------
module trq_ctrl #(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [trq_pkg::KIND_W-1:0]         req_kind,
    input  logic [ID_BITS-1:0]                 req_tid,
    input  logic [ID_BITS-1:0]                 req_rid,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic                               res_dv,
    output logic [ID_BITS-1:0]                 res_did,
    output logic [trq_pkg::STATUS_W-1:0]       res_status,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   res_count,
    output logic                               ram_wr_en,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     ram_wr_addr,
    output logic [ID_BITS-1:0]                 ram_wr_data,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     ram_rd_addr,
    input  logic [ID_BITS-1:0]                 ram_rd_data
);

    import trq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = CNT_W + 1;

    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [ID_BITS-1:0] tid_reg, tid_next;
    logic [ID_BITS-1:0] rid_reg, rid_next;
    logic               pop_reg, pop_next;
    logic               dv_reg, dv_next;
    logic [ID_BITS-1:0] did_reg, did_next;
    status_t            status_reg, status_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    kind_t              in_kind;
    logic               accept;
    logic               is_empty;
    logic               is_full;
    logic               walk;
    logic               match;
    logic               more1;
    logic               more2;
    logic [CMP_W-1:0]   idx_p1;
    logic [CMP_W-1:0]   idx_p2;

    assign in_kind  = kind_t'(req_kind);
    assign accept   = req_valid && (state_reg == ST_IDLE);
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign walk     = (in_kind != KIND_ADD) && !is_empty;
    assign match    = pop_reg || (ram_rd_data == tid_reg);
    assign idx_p1   = CMP_W'(idx_reg) + CMP_W'(1);
    assign idx_p2   = CMP_W'(idx_reg) + CMP_W'(2);
    assign more1    = idx_p1 < CMP_W'(count_reg);
    assign more2    = idx_p2 < CMP_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        kind_reg   <= kind_next;
        tid_reg    <= tid_next;
        rid_reg    <= rid_next;
        pop_reg    <= pop_next;
        dv_reg     <= dv_next;
        did_reg    <= did_next;
        status_reg <= status_next;
        idx_reg    <= idx_next;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = walk ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    if (more1) begin
                        state_next = ST_SHIFT;
                    end else begin
                        state_next = (kind_reg == KIND_QUANTUM) ? ST_APPEND : ST_DONE;
                    end
                end else if (!more1) begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (!more2) begin
                    state_next = (kind_reg == KIND_QUANTUM) ? ST_APPEND : ST_DONE;
                end
            end
            ST_APPEND: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        kind_next   = kind_reg;
        tid_next    = tid_reg;
        rid_next    = rid_reg;
        pop_next    = pop_reg;
        dv_next     = dv_reg;
        did_next    = did_reg;
        status_next = status_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        ram_wr_en   = 1'b0;
        ram_wr_addr = idx_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_addr = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next   = in_kind;
                    tid_next    = req_tid;
                    rid_next    = req_rid;
                    dv_next     = 1'b0;
                    did_next    = '0;
                    status_next = STATUS_OK;
                    idx_next    = '0;
                    pop_next    = 1'b1;
                    unique case (in_kind)
                        KIND_ADD: begin
                            if (is_full) begin
                                status_next = STATUS_FULL;
                            end else begin
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = count_reg[IDX_W-1:0];
                                ram_wr_data = req_tid;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        KIND_YIELD: begin
                            if (is_empty) begin
                                status_next = STATUS_EMPTY;
                            end
                        end
                        KIND_TERMINATE: begin
                            if (req_tid == req_rid) begin
                                if (is_empty) begin
                                    status_next = STATUS_EMPTY;
                                end
                            end else begin
                                pop_next = 1'b0;
                                if (is_empty) begin
                                    status_next = STATUS_NOT_FOUND;
                                end
                            end
                        end
                        KIND_QUANTUM: begin
                            if (is_empty) begin
                                dv_next  = 1'b1;
                                did_next = req_rid;
                            end
                        end
                        default: begin
                            status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (match) begin
                    if (pop_reg) begin
                        dv_next  = 1'b1;
                        did_next = ram_rd_data;
                    end
                    if (more1) begin
                        ram_rd_addr = idx_p1[IDX_W-1:0];
                    end else if (kind_reg != KIND_QUANTUM) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end else if (more1) begin
                    ram_rd_addr = idx_p1[IDX_W-1:0];
                    idx_next    = idx_p1[IDX_W-1:0];
                end else begin
                    status_next = STATUS_NOT_FOUND;
                end
            end
            ST_SHIFT: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                ram_wr_data = ram_rd_data;
                idx_next    = idx_p1[IDX_W-1:0];
                if (more2) begin
                    ram_rd_addr = idx_p2[IDX_W-1:0];
                end else if (kind_reg != KIND_QUANTUM) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_APPEND: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = IDX_W'(count_reg - CNT_W'(1));
                ram_wr_data = rid_reg;
            end
            ST_DONE: begin
                ram_wr_en = 1'b0;
            end
            default: begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    assign req_ready  = (state_reg == ST_IDLE);
    assign res_valid  = (state_reg == ST_DONE);
    assign res_dv     = dv_reg;
    assign res_did    = did_reg;
    assign res_status = status_reg;
    assign res_count  = count_reg;

endmodule

// ===== hw/rtl/thread_ready_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Thread ready queue unit
// FIFO ready queue of thread ids with add, yield, terminate and quantum expiry.
// ----------------------------------------------------------------------------
// Channel  Direction  Fields (lowest bit first)
// s_       in         tdata: kind, thread_id, running_id
// m_       out        tdata: dispatch_valid, dispatch_id, status,
//                            queue_empty_after, entry_count
//
// An add writes its slot without a walk. Yield and terminate walk the occupied
// entries of the slot RAM one entry a cycle, and quantum expiry appends after the
// walk; on an empty queue none of them walks. s_tready is low while a transaction
// is walked or its result waits for the output register. Reset empties the queue
// at once; the slot RAM is not cleared.
// ----------------------------------------------------------------------------
module thread_ready_queue_unit #(
    parameter int QUEUE_DEPTH = trq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ID_BITS     = trq_pkg::DEFAULT_ID_BITS,
    localparam int IN_W  = (((trq_pkg::KIND_W + 2 * ID_BITS) + 7) / 8) * 8,
    localparam int OUT_W =
        (((2 + ID_BITS + trq_pkg::STATUS_W + $clog2(QUEUE_DEPTH + 1)) + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // kind, thread_id, running_id
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // dispatch_valid, dispatch_id, status, queue_empty_after, entry_count
    output logic [OUT_W-1:0] m_tdata
);

    import trq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                res_valid;
    logic                res_ready;
    logic                res_dv;
    logic [ID_BITS-1:0]  res_did;
    logic [STATUS_W-1:0] res_status;
    logic [CNT_W-1:0]    res_count;
    logic                ram_wr_en;
    logic [IDX_W-1:0]    ram_wr_addr;
    logic [ID_BITS-1:0]  ram_wr_data;
    logic [IDX_W-1:0]    ram_rd_addr;
    logic [ID_BITS-1:0]  ram_rd_data;

    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]    m_tdata_reg, m_tdata_next;

    trq_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_kind    (s_tdata[KIND_W-1:0]),
        .req_tid     (s_tdata[KIND_W +: ID_BITS]),
        .req_rid     (s_tdata[KIND_W + ID_BITS +: ID_BITS]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res_dv      (res_dv),
        .res_did     (res_did),
        .res_status  (res_status),
        .res_count   (res_count),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    trq_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'({res_count, (res_count == '0), res_status,
                                    res_did, res_dv});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// Thread ready queue unit testbench
// Drives add, yield, terminate and quantum expiry transactions into the ready
// queue. It predicts each result from a queue model of its own, or takes it from
// the directed table where a row gives one, and checks each field of the returned
// transaction. A short directed table comes first, then biased random traffic,
// with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import trq_pkg::*;

    localparam int QUEUE_DEPTH  = DEFAULT_QUEUE_DEPTH;
    localparam int IN_W         = 24;
    localparam int OUT_W        = 24;
    localparam int RANDOM_OPS   = 900;
    localparam int QUIET_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT      = 450;
    localparam int DIRECTED_OPS = 25;

    typedef struct packed {
        logic [4:0] count;
        logic       empty;
        status_t    status;
        logic [7:0] id;
        logic       dispatched;
    } sched_result_t;

    typedef struct {
        kind_t         kind;
        logic [7:0]    thread_id;
        logic [7:0]    running_id;
        bit            typed;
        sched_result_t result;
    } sched_row_t;

    logic             aclk     = 1'b0;
    logic             aresetn  = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    logic [7:0]    ready_ids[$];
    sched_result_t pending_results[$];
    int            error_count  = 0;
    int            ops_sent     = 0;
    int            results_seen = 0;
    int            quiet_cycles = 0;
    int            peak_depth   = 0;
    int            kind_seen[4];
    int            status_seen[4];

    sched_row_t directed_rows[DIRECTED_OPS] = '{
        '{KIND_YIELD,     8'd0,   8'd0,   1'b1, '{5'd0, 1'b1, STATUS_EMPTY, 8'd0, 1'b0}},
        '{KIND_TERMINATE, 8'd5,   8'd5,   1'b1, '{5'd0, 1'b1, STATUS_EMPTY, 8'd0, 1'b0}},
        '{KIND_TERMINATE, 8'd7,   8'd9,   1'b1,
          '{5'd0, 1'b1, STATUS_NOT_FOUND, 8'd0, 1'b0}},
        '{KIND_QUANTUM,   8'd0,   8'd255, 1'b1, '{5'd0, 1'b1, STATUS_OK, 8'd255, 1'b1}},
        '{KIND_ADD,       8'd0,   8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd255, 8'd255, 1'b0, '0},
        '{KIND_ADD,       8'd255, 8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd1,   8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd2,   8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd4,   8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd8,   8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd16,  8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd32,  8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd64,  8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd128, 8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd170, 8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd85,  8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd254, 8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd127, 8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd3,   8'd0,   1'b0, '0},
        '{KIND_ADD,       8'd99,  8'd0,   1'b1, '{5'd16, 1'b0, STATUS_FULL, 8'd0, 1'b0}},
        '{KIND_QUANTUM,   8'd0,   8'd170, 1'b0, '0},
        '{KIND_TERMINATE, 8'd255, 8'd0,   1'b0, '0},
        '{KIND_TERMINATE, 8'd200, 8'd1,   1'b0, '0},
        '{KIND_TERMINATE, 8'd66,  8'd66,  1'b0, '0}
    };

    thread_ready_queue_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic sched_result_t schedule_op(kind_t kind, logic [7:0] thread_id,
                                                  logic [7:0] running_id);
        sched_result_t res;
        int            i;
        res = '0;
        res.status = STATUS_OK;
        if (kind == KIND_ADD) begin
            if (ready_ids.size() >= QUEUE_DEPTH) begin
                res.status = STATUS_FULL;
            end else begin
                ready_ids.push_back(thread_id);
            end
        end else if (kind == KIND_QUANTUM) begin
            res.dispatched = 1'b1;
            if (ready_ids.size() == 0) begin
                res.id = running_id;
            end else begin
                res.id = ready_ids.pop_front();
                ready_ids.push_back(running_id);
            end
        end else if (kind == KIND_YIELD || thread_id == running_id) begin
            if (ready_ids.size() == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                res.dispatched = 1'b1;
                res.id = ready_ids.pop_front();
            end
        end else begin
            res.status = STATUS_NOT_FOUND;
            for (i = 0; i < ready_ids.size(); i++) begin
                if (ready_ids[i] == thread_id) begin
                    ready_ids.delete(i);
                    res.status = STATUS_OK;
                    break;
                end
            end
        end
        res.empty = (ready_ids.size() == 0);
        res.count = 5'(ready_ids.size());
        if (ready_ids.size() > peak_depth) begin
            peak_depth = ready_ids.size();
        end
        return res;
    endfunction

    function automatic int draw_gap(int index);
        if ((index / 50) % 4 == 0) begin
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    task automatic offer_op(kind_t kind, logic [7:0] thread_id, logic [7:0] running_id,
                            bit typed, sched_result_t typed_result);
        int            gap;
        sched_result_t predicted;
        gap = draw_gap(ops_sent);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, running_id, thread_id, kind};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = schedule_op(kind, thread_id, running_id);
        pending_results.push_back(typed ? typed_result : predicted);
        kind_seen[kind]++;
        ops_sent++;
    endtask

    task automatic offer_random_op(int index);
        int         add_bias;
        int         pick;
        kind_t      kind;
        logic [7:0] thread_id;
        logic [7:0] running_id;
        case ((index / 75) % 3)
            0: add_bias = 80;
            1: add_bias = 50;
            default: add_bias = 25;
        endcase
        thread_id  = 8'($urandom_range(0, 255));
        running_id = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < add_bias) begin
            kind = KIND_ADD;
            if (ready_ids.size() > 0 && $urandom_range(0, 3) == 0) begin
                thread_id = ready_ids[$urandom_range(0, ready_ids.size() - 1)];
            end
        end else begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
                kind = KIND_YIELD;
            end else if (pick < 7) begin
                kind = KIND_TERMINATE;
                pick = $urandom_range(0, 3);
                if (pick == 0) begin
                    thread_id = running_id;
                end else if (pick < 3 && ready_ids.size() > 0) begin
                    thread_id  = ready_ids[$urandom_range(0, ready_ids.size() - 1)];
                    running_id = thread_id ^ 8'($urandom_range(1, 255));
                end
            end else begin
                kind = KIND_QUANTUM;
            end
        end
        offer_op(kind, thread_id, running_id, 1'b0, '0);
    endtask

    initial begin
        int gap;
        sched_result_t want;
        sched_result_t got;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            gap = (results_seen == HOLD_AT) ? LONG_HOLD : draw_gap(results_seen + 17);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            got = sched_result_t'(m_tdata[$bits(sched_result_t)-1:0]);
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction, actual %h", $realtime, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                status_seen[want.status]++;
                if (got.dispatched !== want.dispatched) begin
                    $display("%0t: dispatch_valid expected %0d actual %0d",
                             $realtime, want.dispatched, got.dispatched);
                    error_count++;
                end
                if (got.id !== want.id) begin
                    $display("%0t: dispatch_id expected %0d actual %0d",
                             $realtime, want.id, got.id);
                    error_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $realtime, want.status, got.status);
                    error_count++;
                end
                if (got.empty !== want.empty) begin
                    $display("%0t: queue_empty_after expected %0d actual %0d",
                             $realtime, want.empty, got.empty);
                    error_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $realtime, want.count, got.count);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $realtime, QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[n]) begin
            offer_op(directed_rows[n].kind, directed_rows[n].thread_id,
                     directed_rows[n].running_id, directed_rows[n].typed,
                     directed_rows[n].result);
        end
        for (n = 0; n < RANDOM_OPS; n++) begin
            offer_random_op(n);
        end
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("Ran %0d transactions: %0d add, %0d yield, %0d terminate, %0d quantum expiry.",
                 ops_sent, kind_seen[KIND_ADD], kind_seen[KIND_YIELD],
                 kind_seen[KIND_TERMINATE], kind_seen[KIND_QUANTUM]);
        $display("Status ok %0d, empty %0d, full %0d, not found %0d; peak occupancy %0d.",
                 status_seen[STATUS_OK], status_seen[STATUS_EMPTY],
                 status_seen[STATUS_FULL], status_seen[STATUS_NOT_FOUND], peak_depth);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
